@@ rtl/gbq_pkg.sv @@
// Shared constants, register indexes and button mapping for the gamepad button qualifier.
`default_nettype none

package gbq_pkg;

  // Logical button count and widths
  localparam int unsigned BUTTON_COUNT = 26;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = 15;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CfgRepeatStart    = 3'd0,
    CfgRepeatInterval = 3'd1,
    CfgTriggerThresh  = 3'd2,
    CfgLeftDeadzone   = 3'd3,
    CfgRightDeadzone  = 3'd4
  } cfg_idx_e;

  // Register reset values
  localparam logic [7:0]  RESET_REPEAT_START   = 8'd60;
  localparam logic [7:0]  RESET_REPEAT_INTVL   = 8'd1;
  localparam logic [7:0]  RESET_TRIGGER_THRESH = 8'd30;
  localparam logic [14:0] RESET_LEFT_DZ        = 15'd7849;
  localparam logic [14:0] RESET_RIGHT_DZ       = 15'd8689;

  // Logical positions of the analog-derived buttons
  localparam int unsigned BTN_LEFT_TRIG  = 10;
  localparam int unsigned BTN_RIGHT_TRIG = 11;
  localparam int unsigned BTN_LSTICK_LO  = 16;
  localparam int unsigned BTN_RSTICK_LO  = 21;

  // Reorder raw button word into logical buttons 0..15; trigger slots stay 0
  function automatic logic [15:0] map_buttons(input logic [15:0] word);
    logic [15:0] b;
    b     = '0;
    b[0]  = word[0];   // up
    b[1]  = word[1];   // down
    b[2]  = word[2];   // left
    b[3]  = word[3];   // right
    b[4]  = word[12];  // A
    b[5]  = word[13];  // B
    b[6]  = word[14];  // X
    b[7]  = word[15];  // Y
    b[8]  = word[8];   // left shoulder
    b[9]  = word[9];   // right shoulder
    b[12] = word[6];   // left stick click
    b[13] = word[7];   // right stick click
    b[14] = word[5];   // back
    b[15] = word[4];   // start
    return b;
  endfunction

  // Stick direction bits: up, down, left, right, any
  function automatic logic [4:0] stick_bits(input logic signed [15:0] x,
                                            input logic signed [15:0] y,
                                            input logic [14:0]        dz);
    logic signed [16:0] pos;
    logic signed [16:0] neg;
    logic signed [16:0] xs;
    logic signed [16:0] ys;
    logic [4:0]         b;
    pos  = $signed({2'b00, dz});
    neg  = -pos;
    xs   = 17'(x);
    ys   = 17'(y);
    b[0] = ys > pos;
    b[1] = ys < neg;
    b[2] = xs < neg;
    b[3] = xs > pos;
    b[4] = |b[3:0];
    return b;
  endfunction

endpackage

`default_nettype wire

@@ rtl/gamepad_button_qualifier.sv @@
// Gamepad button qualifier: button levels, edges, auto-repeat and analog deltas.
// A word passes through the input register and then the result register, which offers it.
// Throughput: one word per cycle when out_stall_i is low; an input register and
// the result register let a new word in while out_stall_i holds a finished result.
// Reset clears all button, repeat, delta and prior-value state and loads the
// register defaults; no output word is valid until the first accepted poll.
`default_nettype none

module gamepad_button_qualifier (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // configuration
  input  wire logic                               cfg_we_i,
  input  wire logic [gbq_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [gbq_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  // input channel
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic                               connected_i,
  input  wire logic [15:0]                        button_word_i,
  input  wire logic [7:0]                         left_trigger_i,
  input  wire logic [7:0]                         right_trigger_i,
  input  wire logic signed [15:0]                 left_x_i,
  input  wire logic signed [15:0]                 left_y_i,
  input  wire logic signed [15:0]                 right_x_i,
  input  wire logic signed [15:0]                 right_y_i,
  // output channel
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic                                    link_up_o,
  output logic [gbq_pkg::BUTTON_COUNT-1:0]        pressed_mask_o,
  output logic [gbq_pkg::BUTTON_COUNT-1:0]        rise_mask_o,
  output logic [gbq_pkg::BUTTON_COUNT-1:0]        fall_mask_o,
  output logic [gbq_pkg::BUTTON_COUNT-1:0]        repeat_mask_o,
  output logic signed [8:0]                       left_trigger_delta_o,
  output logic signed [8:0]                       right_trigger_delta_o,
  output logic signed [16:0]                      left_x_delta_o,
  output logic signed [16:0]                      left_y_delta_o,
  output logic signed [16:0]                      right_x_delta_o,
  output logic signed [16:0]                      right_y_delta_o
);

  localparam int unsigned NB = gbq_pkg::BUTTON_COUNT;

  // Configuration registers
  logic [7:0]  rep_start_q, rep_intvl_q, trig_thr_q;
  logic [14:0] left_dz_q, right_dz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rep_start_q <= gbq_pkg::RESET_REPEAT_START;
      rep_intvl_q <= gbq_pkg::RESET_REPEAT_INTVL;
      trig_thr_q  <= gbq_pkg::RESET_TRIGGER_THRESH;
      left_dz_q   <= gbq_pkg::RESET_LEFT_DZ;
      right_dz_q  <= gbq_pkg::RESET_RIGHT_DZ;
    end else if (cfg_we_i) begin
      case (gbq_pkg::cfg_idx_e'(cfg_idx_i))
        gbq_pkg::CfgRepeatStart:    rep_start_q <= cfg_wdata_i[7:0];
        gbq_pkg::CfgRepeatInterval: rep_intvl_q <= cfg_wdata_i[7:0];
        gbq_pkg::CfgTriggerThresh:  trig_thr_q  <= cfg_wdata_i[7:0];
        gbq_pkg::CfgLeftDeadzone:   left_dz_q   <= cfg_wdata_i;
        gbq_pkg::CfgRightDeadzone:  right_dz_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Handshake: input stage moves into the result stage when that is free
  logic s1_valid_q, out_valid_q, adv, in_acc;

  assign adv        = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (adv) begin
        s1_valid_q <= 1'b0;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Input register
  logic               s1_conn_q;
  logic [15:0]        s1_word_q;
  logic [7:0]         s1_lt_q, s1_rt_q;
  logic signed [15:0] s1_lx_q, s1_ly_q, s1_rx_q, s1_ry_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_conn_q <= connected_i;
      s1_word_q <= button_word_i;
      s1_lt_q   <= left_trigger_i;
      s1_rt_q   <= right_trigger_i;
      s1_lx_q   <= left_x_i;
      s1_ly_q   <= left_y_i;
      s1_rx_q   <= right_x_i;
      s1_ry_q   <= right_y_i;
    end
  end

  // Result and per-button state
  logic [NB-1:0]      pressed_q, rise_q, fall_q, repeat_q;
  logic [7:0]         hold_q  [NB];
  logic [7:0]         phase_q [NB];
  logic [7:0]         prior_lt_q, prior_rt_q;
  logic signed [15:0] prior_lx_q, prior_ly_q, prior_rx_q, prior_ry_q;
  logic signed [8:0]  lt_chg_q, rt_chg_q;
  logic signed [16:0] lx_chg_q, ly_chg_q, rx_chg_q, ry_chg_q;
  logic               link_q;

  // Button levels
  logic [NB-1:0] now;
  logic [15:0]   dig;

  always_comb begin
    dig = gbq_pkg::map_buttons(s1_word_q);
    now = '0;
    now[15:0] = dig;
    now[gbq_pkg::BTN_LEFT_TRIG]  = s1_lt_q > trig_thr_q;
    now[gbq_pkg::BTN_RIGHT_TRIG] = s1_rt_q > trig_thr_q;
    now[gbq_pkg::BTN_LSTICK_LO +: 5] = gbq_pkg::stick_bits(s1_lx_q, s1_ly_q, left_dz_q);
    now[gbq_pkg::BTN_RSTICK_LO +: 5] = gbq_pkg::stick_bits(s1_rx_q, s1_ry_q, right_dz_q);
  end

  // Typematic repeat, one lane per button
  logic [NB-1:0] rep_d;
  logic [7:0]    hold_d  [NB];
  logic [7:0]    phase_d [NB];

  always_comb begin
    for (int i = 0; i < NB; i++) begin
      rep_d[i]   = 1'b0;
      hold_d[i]  = hold_q[i];
      phase_d[i] = phase_q[i];
      if (now[i]) begin
        if (hold_q[i] == 8'd0) begin
          rep_d[i] = 1'b1;
        end else if (hold_q[i] >= rep_start_q) begin
          if (phase_q[i] == 8'd0) begin
            rep_d[i] = 1'b1;
          end
          // phase wraps at the interval; an interval of zero acts as one
          if (({1'b0, phase_q[i]} + 9'd1) >= {1'b0, rep_intvl_q}) begin
            phase_d[i] = 8'd0;
          end else begin
            phase_d[i] = phase_q[i] + 8'd1;
          end
        end
        if (hold_q[i] < rep_start_q) begin
          hold_d[i] = hold_q[i] + 8'd1;
        end
      end else begin
        hold_d[i]  = 8'd0;
        phase_d[i] = 8'd0;
      end
    end
  end

  // Analog deltas against the previous connected poll
  logic signed [8:0]  lt_chg_d, rt_chg_d;
  logic signed [16:0] lx_chg_d, ly_chg_d, rx_chg_d, ry_chg_d;

  always_comb begin
    lt_chg_d = $signed({1'b0, s1_lt_q}) - $signed({1'b0, prior_lt_q});
    rt_chg_d = $signed({1'b0, s1_rt_q}) - $signed({1'b0, prior_rt_q});
    lx_chg_d = 17'(s1_lx_q) - 17'(prior_lx_q);
    ly_chg_d = 17'(s1_ly_q) - 17'(prior_ly_q);
    rx_chg_d = 17'(s1_rx_q) - 17'(prior_rx_q);
    ry_chg_d = 17'(s1_ry_q) - 17'(prior_ry_q);
  end

  // State update; a disconnected poll only refreshes the link flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_q     <= 1'b0;
      pressed_q  <= '0;
      rise_q     <= '0;
      fall_q     <= '0;
      repeat_q   <= '0;
      prior_lt_q <= '0;
      prior_rt_q <= '0;
      prior_lx_q <= '0;
      prior_ly_q <= '0;
      prior_rx_q <= '0;
      prior_ry_q <= '0;
      lt_chg_q   <= '0;
      rt_chg_q   <= '0;
      lx_chg_q   <= '0;
      ly_chg_q   <= '0;
      rx_chg_q   <= '0;
      ry_chg_q   <= '0;
      for (int i = 0; i < NB; i++) begin
        hold_q[i]  <= '0;
        phase_q[i] <= '0;
      end
    end else if (adv) begin
      link_q <= s1_conn_q;
      if (s1_conn_q) begin
        pressed_q  <= now;
        rise_q     <= now & ~pressed_q;
        fall_q     <= pressed_q & ~now;
        repeat_q   <= rep_d;
        prior_lt_q <= s1_lt_q;
        prior_rt_q <= s1_rt_q;
        prior_lx_q <= s1_lx_q;
        prior_ly_q <= s1_ly_q;
        prior_rx_q <= s1_rx_q;
        prior_ry_q <= s1_ry_q;
        lt_chg_q   <= lt_chg_d;
        rt_chg_q   <= rt_chg_d;
        lx_chg_q   <= lx_chg_d;
        ly_chg_q   <= ly_chg_d;
        rx_chg_q   <= rx_chg_d;
        ry_chg_q   <= ry_chg_d;
        for (int i = 0; i < NB; i++) begin
          hold_q[i]  <= hold_d[i];
          phase_q[i] <= phase_d[i];
        end
      end
    end
  end

  // Outputs come straight from the result state
  assign out_valid_o           = out_valid_q;
  assign link_up_o             = link_q;
  assign pressed_mask_o        = pressed_q;
  assign rise_mask_o           = rise_q;
  assign fall_mask_o           = fall_q;
  assign repeat_mask_o         = repeat_q;
  assign left_trigger_delta_o  = lt_chg_q;
  assign right_trigger_delta_o = rt_chg_q;
  assign left_x_delta_o        = lx_chg_q;
  assign left_y_delta_o        = ly_chg_q;
  assign right_x_delta_o       = rx_chg_q;
  assign right_y_delta_o       = ry_chg_q;

endmodule

`default_nettype wire
